[hdl/save_image_header_crc_checker_unit_macros.svh]
// Assertion macros for the save image header CRC checker.
`ifndef SAVE_IMAGE_HEADER_CRC_CHECKER_UNIT_MACROS_SVH
`define SAVE_IMAGE_HEADER_CRC_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SIHCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sihcc same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define SIHCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sihcc next-cycle check failed");

`endif

[hdl/sihcc_pkg.sv]
// Package: types, constants and CRC function for the save image header checker.
`timescale 1ns / 1ps

package sihcc_pkg;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CORRUPT = 2'd1,
        STATUS_VERSION = 2'd2,
        STATUS_CRC     = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0]        payload_length;
        logic signed [63:0] timestamp;
        logic               compressed;
        logic [15:0]        format_version;
        status_t            status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_OUT_W = ((RESULT_W + 7) / 8) * 8;
    localparam int PAD_W = TDATA_OUT_W - RESULT_W;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] HEADER_LAST = 32'd31;
    localparam logic [15:0] VERSION_RST = 16'd1;

    localparam logic [7:0] MAGIC [4] = '{8'h4B, 8'h41, 8'h37, 8'h00};

    // Reflected CRC-32 update over one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

[hdl/save_image_header_crc_checker_unit.sv]
// Save image header CRC checker: one verdict per file from a byte stream.
// Input channel s_*: one file byte per transfer, s_tlast on the final byte.
// Output channel m_*: one verdict per file, carrying status and header fields.
// A file gives its verdict on the byte that decides it (bad magic, version,
// length or CRC result), or on its last byte if it ends early; bytes after a
// verdict are dropped until s_tlast, which starts the next file.
// Config: cfg_wr_en/cfg_wr_data set the highest accepted version (reset 1);
// write only while no file is in progress and no verdict is pending.
// Throughput: one byte per cycle while s_tready is high; the CRC update and
// header capture are combinational between the state and output registers.
// Latency: the verdict appears on m_tvalid the cycle after the deciding byte.
// A stalled m_tready holds the verdict; s_tready stays high as long as the
// output register is empty or drains in the same cycle.
// Reset clears the file state, CRC and the pending verdict at once.
`timescale 1ns / 1ps
`include "save_image_header_crc_checker_unit_macros.svh"

module save_image_header_crc_checker_unit
    import sihcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] file_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] status, [17:2] format_version, [18] compressed,
    // [82:19] timestamp, [114:83] payload_length, rest zero
    output logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data
);

    logic    in_xfer;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign in_xfer = s_tvalid && s_tready;

    sihcc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_xfer),
        .file_byte  (s_tdata),
        .last_byte  (s_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .res_valid  (res_valid),
        .res        (res)
    );

    sihcc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .load_data(res),
        .room     (s_tready),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .out_data (out_data)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_data};

    `SIHCC_ASSERT_SAME(a_res_only_on_xfer, clk, rst_n, res_valid, in_xfer)
    `SIHCC_ASSERT_NEXT(a_res_reaches_out, clk, rst_n, res_valid, m_tvalid)
    `SIHCC_ASSERT_SAME(a_no_accept_when_full, clk, rst_n, m_tvalid && !m_tready, !s_tready)

endmodule

[hdl/sihcc_parser.sv]
// Header parser, payload CRC and verdict logic for the save image checker.
`timescale 1ns / 1ps

module sihcc_parser
    import sihcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  file_byte,
    input  logic        last_byte,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        res_valid,
    output result_t     res
);

    logic [31:0]        pos_reg, pos_next;
    logic [31:0]        crc_reg, crc_next;
    logic               done_reg, done_next;
    logic [15:0]        cur_ver_reg;

    logic [15:0]        ver_reg, ver_next;
    logic               comp_reg, comp_next;
    logic [63:0]        time_reg, time_next;
    logic [31:0]        exp_crc_reg, exp_crc_next;
    logic [31:0]        exp_len_reg, exp_len_next;

    logic               have;
    status_t            verdict;
    logic [31:0]        crc_upd;
    logic               header_done;

    assign crc_upd     = crc_byte(crc_reg, file_byte);
    assign header_done = (pos_reg >= HEADER_LAST);

    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        done_next    = done_reg;
        ver_next     = ver_reg;
        comp_next    = comp_reg;
        time_next    = time_reg;
        exp_crc_next = exp_crc_reg;
        exp_len_next = exp_len_reg;
        have         = 1'b0;
        verdict      = STATUS_OK;
        if (accept)
        begin
            if (!done_reg)
            begin
                if (pos_reg < 32'd4)
                begin
                    if (file_byte != MAGIC[pos_reg[1:0]])
                    begin
                        have    = 1'b1;
                        verdict = STATUS_CORRUPT;
                    end
                end
                else if (pos_reg <= HEADER_LAST)
                begin
                    if (pos_reg < 32'd6)
                        ver_next[{pos_reg[0], 3'b000} +: 8] = file_byte;
                    else if (pos_reg == 32'd6)
                        comp_next = file_byte[0];
                    else if (pos_reg >= 32'd8 && pos_reg < 32'd16)
                        time_next[{pos_reg[2:0], 3'b000} +: 8] = file_byte;
                    else if (pos_reg >= 32'd16 && pos_reg < 32'd20)
                        exp_crc_next[{pos_reg[1:0], 3'b000} +: 8] = file_byte;
                    else if (pos_reg >= 32'd20 && pos_reg < 32'd24)
                        exp_len_next[{pos_reg[1:0], 3'b000} +: 8] = file_byte;

                    if (pos_reg == HEADER_LAST)
                    begin
                        priority if (ver_reg > cur_ver_reg)
                        begin
                            have    = 1'b1;
                            verdict = STATUS_VERSION;
                        end
                        else if (exp_len_reg[31])
                        begin
                            have    = 1'b1;
                            verdict = STATUS_CORRUPT;
                        end
                        else if (exp_len_reg == 32'd0)
                        begin
                            have    = 1'b1;
                            verdict = (exp_crc_reg == 32'd0) ? STATUS_OK : STATUS_CRC;
                        end
                    end
                end
                else
                begin
                    crc_next = crc_upd;
                    if ((pos_reg - HEADER_LAST) == exp_len_reg)
                    begin
                        have    = 1'b1;
                        verdict = ((~crc_upd) == exp_crc_reg) ? STATUS_OK : STATUS_CRC;
                    end
                end
                if (have)
                    done_next = 1'b1;
                else
                    pos_next = pos_reg + 32'd1;
            end
            if (last_byte)
            begin
                pos_next  = '0;
                crc_next  = CRC_INIT;
                done_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res_valid = accept && !done_reg && (have || last_byte);
        res       = '0;
        res.status = have ? verdict : STATUS_CORRUPT;
        if (header_done)
        begin
            res.format_version = ver_reg;
            res.compressed     = comp_reg;
            res.timestamp      = time_reg;
            res.payload_length = exp_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            done_reg    <= 1'b0;
            cur_ver_reg <= VERSION_RST;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            done_reg <= done_next;
            if (cfg_wr_en)
                cur_ver_reg <= cfg_wr_data;
        end
    end

    // Header fields: every one is rewritten before it is used in a file.
    always_ff @(posedge clk)
    begin
        ver_reg     <= ver_next;
        comp_reg    <= comp_next;
        time_reg    <= time_next;
        exp_crc_reg <= exp_crc_next;
        exp_len_reg <= exp_len_next;
    end

endmodule

[hdl/sihcc_out_stage.sv]
// Output register for verdict transfers, with ready passed back upstream.
`timescale 1ns / 1ps

module sihcc_out_stage
    import sihcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    room,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;

    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule

[test/save_image_header_crc_checker_unit_tb.sv]
// Testbench for the save image header CRC checker: random and directed files, scoreboard.
`timescale 1ns / 1ps

module save_image_header_crc_checker_unit_tb;
    import sihcc_pkg::*;

    localparam logic [7:0]  MAGIC_K [4] = '{8'h4B, 8'h41, 8'h37, 8'h00};
    localparam logic [31:0] LEN_MAX     = 32'h7FFF_FFFF;
    localparam int          BYTE_TARGET = 1950;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [15:0]            cfg_wr_data = '0;

    save_image_header_crc_checker_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // verdict predictor state
    logic [15:0] max_version = VERSION_RST;
    logic [31:0] file_pos;
    logic [31:0] crc_acc;
    logic [15:0] hdr_ver;
    logic [15:0] hdr_flags;
    logic [63:0] hdr_time;
    logic [31:0] hdr_crc;
    logic [31:0] hdr_len;
    bit          verdict_done;

    result_t verdict_q[$];

    int  errors = 0;
    int  mismatches = 0;
    int  verdicts_seen = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    int  counted_bytes = 0;
    int  sent_bytes = 0;
    int  files_sent = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    int  rx_hold = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] acc;
        logic        fb;
        acc = c;
        for (int i = 0; i < 8; i++)
        begin
            fb = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    task automatic clear_file();
        file_pos = '0;
        crc_acc = 32'hFFFF_FFFF;
        hdr_ver = '0;
        hdr_flags = '0;
        hdr_time = '0;
        hdr_crc = '0;
        hdr_len = '0;
        verdict_done = 1'b0;
    endtask

    task automatic predict_verdict(input logic [7:0] b, input logic last);
        result_t     r;
        status_t     st;
        bit          have;
        logic [31:0] p;
        if (verdict_done)
        begin
            if (last)
                clear_file();
            return;
        end
        counted_bytes++;
        p = file_pos;
        have = 1'b0;
        st = STATUS_OK;
        if (p < 4)
        begin
            if (b != MAGIC_K[p[1:0]])
            begin
                have = 1'b1;
                st = STATUS_CORRUPT;
            end
        end
        else if (p < 32)
        begin
            if (p < 6)
                hdr_ver[(p - 4) * 8 +: 8] = b;
            else if (p < 8)
                hdr_flags[(p - 6) * 8 +: 8] = b;
            else if (p < 16)
                hdr_time[(p - 8) * 8 +: 8] = b;
            else if (p < 20)
                hdr_crc[(p - 16) * 8 +: 8] = b;
            else if (p < 24)
                hdr_len[(p - 20) * 8 +: 8] = b;
            if (p == 31)
            begin
                if (hdr_ver > max_version)
                begin
                    have = 1'b1;
                    st = STATUS_VERSION;
                end
                else if (hdr_len > LEN_MAX)
                begin
                    have = 1'b1;
                    st = STATUS_CORRUPT;
                end
                else if (hdr_len == 0)
                begin
                    have = 1'b1;
                    if (hdr_crc == 0)
                        st = STATUS_OK;
                    else
                        st = STATUS_CRC;
                end
            end
        end
        else
        begin
            crc_acc = crc_step(crc_acc, b);
            if (p - 31 == hdr_len)
            begin
                have = 1'b1;
                if (~crc_acc == hdr_crc)
                    st = STATUS_OK;
                else
                    st = STATUS_CRC;
            end
        end
        if (!have)
            file_pos = p + 1;
        if (have || last)
        begin
            r = '0;
            if (have)
                r.status = st;
            else
                r.status = STATUS_CORRUPT;
            if (p >= 31)
            begin
                r.format_version = hdr_ver;
                r.compressed = hdr_flags[0];
                r.timestamp = hdr_time;
                r.payload_length = hdr_len;
            end
            verdict_q = {verdict_q, r};
            if (have)
                verdict_done = 1'b1;
        end
        if (last)
            clear_file();
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        result_t                   got;
        result_t                   want;
        logic [TDATA_OUT_W-1:0]    raw;
        bit                        bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            raw = m_tdata;
            got = raw[RESULT_W-1:0];
            verdicts_seen++;
            status_seen[got.status]++;
            if (verdict_q.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected verdict %h", $realtime, raw);
            end
            else
            begin
                want = verdict_q.pop_front();
                bad = (got.status !== want.status)
                   || (got.format_version !== want.format_version)
                   || (got.compressed !== want.compressed)
                   || (got.timestamp !== want.timestamp)
                   || (got.payload_length !== want.payload_length)
                   || (raw[TDATA_OUT_W-1:RESULT_W] !== '0);
                if (bad)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: verdict mismatch", $realtime);
                        $display("  exp st=%0d ver=%h cmp=%b ts=%h len=%h", want.status,
                                 want.format_version, want.compressed, want.timestamp,
                                 want.payload_length);
                        $display("  got st=%0d ver=%h cmp=%b ts=%h len=%h pad=%h", got.status,
                                 got.format_version, got.compressed, got.timestamp,
                                 got.payload_length, raw[TDATA_OUT_W-1:RESULT_W]);
                    end
                end
            end
        end
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else if (!rx_quiet && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            rx_hold = gap_len() - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (!tx_quiet && $urandom_range(0, 3) == 0)
            gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        sent_bytes++;
        predict_verdict(b, last);
    endtask

    // keep < 0 sends the whole file; magic_err < 0 keeps the magic intact
    task automatic send_file(input logic [15:0] ver, input logic [15:0] flags,
                             input logic [63:0] ts, input logic [31:0] len_field,
                             input int plen, input bit crc_bad, input int keep,
                             input int trailing, input int magic_err);
        logic [7:0]  fbytes[$];
        logic [7:0]  pay[$];
        logic [7:0]  b;
        logic [31:0] c;
        logic [31:0] crc_field;
        int          n;
        c = 32'hFFFF_FFFF;
        for (int i = 0; i < plen; i++)
        begin
            b = $urandom;
            pay = {pay, b};
            c = crc_step(c, b);
        end
        crc_field = ~c;
        if (crc_bad)
            crc_field = crc_field ^ ($urandom | 32'd1);
        for (int i = 0; i < 4; i++)
        begin
            if (i == magic_err)
                fbytes = {fbytes, MAGIC_K[i] ^ 8'($urandom_range(1, 255))};
            else
                fbytes = {fbytes, MAGIC_K[i]};
        end
        for (int i = 0; i < 2; i++)
            fbytes = {fbytes, ver[i*8 +: 8]};
        for (int i = 0; i < 2; i++)
            fbytes = {fbytes, flags[i*8 +: 8]};
        for (int i = 0; i < 8; i++)
            fbytes = {fbytes, ts[i*8 +: 8]};
        for (int i = 0; i < 4; i++)
            fbytes = {fbytes, crc_field[i*8 +: 8]};
        for (int i = 0; i < 4; i++)
            fbytes = {fbytes, len_field[i*8 +: 8]};
        for (int i = 0; i < 8; i++)
            fbytes = {fbytes, 8'($urandom)};
        fbytes = {fbytes, pay};
        for (int i = 0; i < trailing; i++)
            fbytes = {fbytes, 8'($urandom)};
        n = fbytes.size();
        if (keep >= 1 && keep < n)
            n = keep;
        for (int i = 0; i < n; i++)
            send_byte(fbytes[i], i == n - 1);
        files_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_version(input logic [15:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_version = v;
    endtask

    function automatic int pick_plen();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 16);
        else if (r < 97)
            return $urandom_range(17, 64);
        return $urandom_range(65, 300);
    endfunction

    function automatic logic [63:0] rand64();
        return {32'($urandom), 32'($urandom)};
    endfunction

    task automatic test_good_files();
        send_file(16'd1, 16'hFFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 0, 1'b0, -1, 0, -1);
        send_file(16'd0, 16'h0000, 64'h8000_0000_0000_0000, 32'd0, 0, 1'b1, -1, 0, -1);
        send_file(16'd1, 16'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1, 1'b0, -1, 0, -1);
        send_file(16'd0, 16'hFFFE, rand64(), 32'd5, 5, 1'b1, -1, 0, -1);
        send_file(16'd1, 16'h5A5A, rand64(), 32'd9, 9, 1'b0, -1, 3, -1);
    endtask

    task automatic test_magic_errors();
        for (int i = 0; i < 4; i++)
            send_file(16'd1, 16'd0, rand64(), 32'd4, 4, 1'b0, -1, 2, i);
        send_byte(MAGIC_K[0], 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_version_limit();
        send_file(16'd2, 16'd1, rand64(), 32'd3, 3, 1'b0, -1, 0, -1);
        send_file(16'hFFFF, 16'd0, rand64(), 32'hFFFF_FFFF, 2, 1'b0, -1, 0, -1);
        set_version(16'd0);
        send_file(16'd0, 16'd1, rand64(), 32'd2, 2, 1'b0, -1, 0, -1);
        send_file(16'd1, 16'd1, rand64(), 32'd2, 2, 1'b0, -1, 0, -1);
        set_version(16'hFFFF);
        send_file(16'hFFFF, 16'd3, rand64(), 32'd2, 2, 1'b0, -1, 1, -1);
    endtask

    task automatic test_length_limit();
        send_file(16'd7, 16'd0, rand64(), 32'h8000_0000, 3, 1'b0, -1, 0, -1);
        send_file(16'd7, 16'd1, rand64(), 32'hFFFF_FFFF, 0, 1'b0, -1, 0, -1);
        send_file(16'd7, 16'd1, rand64(), LEN_MAX, 4, 1'b0, -1, 0, -1);
    endtask

    task automatic test_truncation();
        send_file(16'd1, 16'd1, rand64(), 32'd8, 8, 1'b0, 1, 0, -1);
        send_file(16'd1, 16'd1, rand64(), 32'd8, 8, 1'b0, 4, 0, -1);
        send_file(16'd1, 16'd1, rand64(), 32'd8, 8, 1'b0, 24, 0, -1);
        send_file(16'd1, 16'd1, rand64(), 32'd8, 8, 1'b0, 31, 0, -1);
        send_file(16'd1, 16'd1, rand64(), 32'd8, 8, 1'b0, 32, 0, -1);
        send_file(16'd1, 16'd1, rand64(), 32'd20, 20, 1'b0, 40, 0, -1);
        send_file(16'd1, 16'd0, rand64(), 32'd6, 6, 1'b1, 38, 0, -1);
    endtask

    task automatic test_random_files();
        logic [15:0] phase_ver[5];
        logic [15:0] v;
        int          goal;
        int          kind;
        int          plen;
        int          n;
        phase_ver = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom), 16'd300};
        for (int ph = 0; ph < 5; ph++)
        begin
            set_version(phase_ver[ph]);
            tx_quiet = (ph == 1);
            rx_quiet = (ph == 1 || ph == 3);
            goal = sent_bytes + (BYTE_TARGET - sent_bytes) / (5 - ph);
            while (sent_bytes < goal)
            begin
                kind = $urandom_range(0, 99);
                plen = pick_plen();
                v = 16'($urandom_range(0, int'(max_version)));
                if (kind < 55 || (kind < 65 && max_version == 16'hFFFF))
                    send_file(v, 16'($urandom), rand64(), 32'(plen), plen,
                              $urandom_range(0, 2) == 0, -1,
                              ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0, -1);
                else if (kind < 65)
                    send_file(16'($urandom_range(int'(max_version) + 1, 65535)),
                              16'($urandom), rand64(), 32'(plen), plen, 1'b0, -1,
                              $urandom_range(0, 2), -1);
                else if (kind < 72)
                    send_file(v, 16'($urandom), rand64(), 32'h8000_0000 | $urandom,
                              plen, 1'b0, -1, 0, -1);
                else if (kind < 82)
                begin
                    plen = plen + 1;
                    send_file(v, 16'($urandom), rand64(), 32'(plen), plen, 1'b0,
                              $urandom_range(1, 31 + plen), 0, -1);
                end
                else if (kind < 90)
                    send_file(v, 16'($urandom), rand64(), 32'(plen), plen, 1'b0, -1,
                              $urandom_range(0, 4), $urandom_range(0, 3));
                else
                begin
                    n = $urandom_range(1, 40);
                    for (int i = 0; i < n; i++)
                        send_byte(8'($urandom), i == n - 1);
                end
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        clear_file();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_good_files();
        test_magic_errors();
        test_version_limit();
        test_length_limit();
        test_truncation();
        test_random_files();
        wait_drained();
        repeat (8) @(posedge clk);
        if (verdict_q.size() != 0)
            errors++;
        $display("Run covered %0d files, %0d bytes sent, %0d judged bytes, %0d verdicts",
                 files_sent, sent_bytes, counted_bytes, verdicts_seen);
        $display("Verdicts ok/corrupt/version/crc: %0d/%0d/%0d/%0d, mismatches %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
